[src/circular_orbit_position_generator_core_macros.svh]
// Assertion macros shared by the orbit position generator RTL files.
`ifndef CIRCULAR_ORBIT_POSITION_GENERATOR_CORE_MACROS_SVH
`define CIRCULAR_ORBIT_POSITION_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define COPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define COPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/copg_pkg.sv]
// Shared types, constants and the CORDIC angle table of the orbit position generator.
package copg_pkg;

  localparam int PhaseBitsDef    = 32;
  localparam int CordicStagesDef = 16;
  localparam int AngleTableLen   = 24;

  localparam int TimeW      = 32;
  localparam int RadiusW    = 16;
  localparam int PhaseStepW = 32;
  localparam int TimeStepW  = 16;
  localparam int PosW       = 17;
  localparam int TrigW      = 17;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;

  // Datapath widths of the CORDIC cells (Q2.30 vectors with headroom, angle in turn * 2^32).
  localparam int XW = 34;
  localparam int ZW = 34;

  // CORDIC gain 0.6072529 in Q2.30.
  localparam logic signed [XW-1:0] CordicGain = XW'(652032874);

  // atan(2^-i) in units of turn * 2^32, rounded.
  localparam logic [31:0] AngleTable [AngleTableLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331, 32'd21354465,
    32'd10679838,  32'd5340245,   32'd2670163,   32'd1335087,  32'd667544,   32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,    32'd10430,    32'd5215,
    32'd2608,      32'd1304,      32'd652,       32'd326,      32'd163,      32'd81
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgRadius    = 2'd0,
    CfgPhaseStep = 2'd1,
    CfgTimeStep  = 2'd2
  } copg_cfg_reg_e;

  // Quarter turn the phase was rounded to before the CORDIC rotation.
  typedef enum logic [1:0] {
    Quad0   = 2'd0,
    Quad90  = 2'd1,
    Quad180 = 2'd2,
    Quad270 = 2'd3
  } copg_quad_e;

  // Data carried from one CORDIC cell to the next.
  typedef struct packed {
    logic [TimeW-1:0]       elapsed;
    copg_quad_e             quad;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } copg_cell_t;

endpackage

[src/copg_cordic_cell.sv]
// One rotation-mode CORDIC micro-rotation, registered, with its own valid/ready handshake.
module copg_cordic_cell #(
  parameter int unsigned StageIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  copg_pkg::copg_cell_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output copg_pkg::copg_cell_t data_o
);
  import copg_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] angle;
  copg_cell_t           data_d;
  copg_cell_t           data_q;
  logic                 valid_q;

  assign dx    = data_i.y >>> StageIdx;
  assign dy    = data_i.x >>> StageIdx;
  assign angle = $signed(ZW'(AngleTable[StageIdx]));

  // Rotate toward zero residual angle.
  always_comb begin
    data_d = data_i;
    if (!data_i.z[ZW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - angle;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + angle;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/copg_scale.sv]
// Rounding, quadrant mapping and radius scaling stages behind the CORDIC chain.
module copg_scale (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  copg_pkg::copg_cell_t                  data_i,
  input  logic [copg_pkg::RadiusW-1:0]          radius_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [copg_pkg::TimeW-1:0]            elapsed_o,
  output logic signed [copg_pkg::PosW-1:0]      x_o,
  output logic signed [copg_pkg::PosW-1:0]      y_o
);
  import copg_pkg::*;

  `include "circular_orbit_position_generator_core_macros.svh"

  localparam logic signed [XW-1:0]    QMax   = XW'(32768);
  localparam logic signed [XW-1:0]    QMin   = -QMax;
  localparam logic signed [XW-1:0]    QHalf  = XW'(16384);
  localparam logic signed [TrigW-1:0] TrigMax = TrigW'(32768);
  localparam logic signed [TrigW-1:0] TrigMin = -TrigMax;

  // Round half up to Q.15 and clamp to plus or minus one.
  function automatic logic signed [TrigW-1:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + QHalf) >>> 15;
    if (r > QMax) begin
      r = QMax;
    end else if (r < QMin) begin
      r = QMin;
    end
    return TrigW'(r);
  endfunction

  logic                     a_ready;
  logic                     b_ready;
  logic                     c_ready;

  logic signed [TrigW-1:0]  x_r;
  logic signed [TrigW-1:0]  y_r;
  logic signed [TrigW-1:0]  cs_d;
  logic signed [TrigW-1:0]  sn_d;

  logic                     a_valid_q;
  logic [TimeW-1:0]         a_time_q;
  logic signed [TrigW-1:0]  a_cs_q;
  logic signed [TrigW-1:0]  a_sn_q;

  logic signed [TrigW-1:0]  cs_abs;
  logic signed [TrigW-1:0]  sn_abs;
  logic [2*RadiusW-1:0]     prod_x;
  logic [2*RadiusW-1:0]     prod_y;

  logic                     b_valid_q;
  logic [TimeW-1:0]         b_time_q;
  logic [RadiusW-1:0]       b_px_q;
  logic [RadiusW-1:0]       b_py_q;
  logic                     b_negx_q;
  logic                     b_negy_q;

  logic                     c_valid_q;
  logic [TimeW-1:0]         c_time_q;
  logic signed [PosW-1:0]   c_x_q;
  logic signed [PosW-1:0]   c_y_q;
  logic signed [PosW-1:0]   px_ext;
  logic signed [PosW-1:0]   py_ext;

  assign c_ready = !c_valid_q || ready_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // Stage A: round the CORDIC vector and rotate it back by the quarter turn.
  assign x_r = to_q15(data_i.x);
  assign y_r = to_q15(data_i.y);

  always_comb begin
    unique case (data_i.quad)
      Quad0: begin
        cs_d = x_r;
        sn_d = y_r;
      end
      Quad90: begin
        cs_d = -y_r;
        sn_d = x_r;
      end
      Quad180: begin
        cs_d = -x_r;
        sn_d = -y_r;
      end
      Quad270: begin
        cs_d = y_r;
        sn_d = -x_r;
      end
    endcase
  end

  // Stage B: magnitude times radius, truncated after the shift by 15.
  assign cs_abs = a_cs_q[TrigW-1] ? -a_cs_q : a_cs_q;
  assign sn_abs = a_sn_q[TrigW-1] ? -a_sn_q : a_sn_q;
  assign prod_x = cs_abs[RadiusW-1:0] * radius_i;
  assign prod_y = sn_abs[RadiusW-1:0] * radius_i;

  // Stage C: restore the sign, which truncates toward zero.
  assign px_ext = $signed({1'b0, b_px_q});
  assign py_ext = $signed({1'b0, b_py_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_time_q <= data_i.elapsed;
      a_cs_q   <= cs_d;
      a_sn_q   <= sn_d;
    end
    if (b_ready && a_valid_q) begin
      b_time_q <= a_time_q;
      b_px_q   <= prod_x[RadiusW+14:15];
      b_py_q   <= prod_y[RadiusW+14:15];
      b_negx_q <= a_cs_q[TrigW-1];
      b_negy_q <= a_sn_q[TrigW-1];
    end
    if (c_ready && b_valid_q) begin
      c_time_q <= b_time_q;
      c_x_q    <= b_negx_q ? -px_ext : px_ext;
      c_y_q    <= b_negy_q ? -py_ext : py_ext;
    end
  end

  assign valid_o   = c_valid_q;
  assign elapsed_o = c_time_q;
  assign x_o       = c_x_q;
  assign y_o       = c_y_q;

  `COPG_ASSERT_IMP(a_trig_in_range, a_valid_q, (a_cs_q <= TrigMax) && (a_cs_q >= TrigMin) && (a_sn_q <= TrigMax) && (a_sn_q >= TrigMin), "rounded trig value out of range")
  `COPG_ASSERT_NXT(c_load_from_b, c_ready && b_valid_q, c_valid_q, "stage C dropped a transaction")

endmodule

[src/circular_orbit_position_generator_core.sv]
// Top level of the circular orbit position generator: phase accumulator, CORDIC cell chain, scaling.
//
// Usage: every transaction on the tick channel (tick_valid_i/tick_ready_o, payload tick_i)
// with tick_i high produces exactly one transaction on the result channel
// (out_valid_o/out_ready_i) carrying the elapsed time before the step and the point
// radius * (cos phase, sin phase). A transaction with tick_i low is consumed and dropped.
// From acceptance to out_valid_o a result passes the entry register, one register per
// CORDIC cell and three output stages. While out_ready_i stays high, throughput is one
// transaction per cycle: every stage is a register with its own valid bit, and a stage
// loads whenever it is empty or its successor moves on.
// When the receiver stalls, results collect in the chain until every stage is full,
// then tick_ready_o drops; nothing is lost or repeated.
// Reset clears phase and time to zero, radius and phase_step to zero, time_step to one,
// and empties the pipeline. Registers are written through cfg_we_i/cfg_index_i/cfg_data_i
// and should only change while no transaction is in flight.
module circular_orbit_position_generator_core #(
  parameter int PhaseBits    = copg_pkg::PhaseBitsDef,
  parameter int CordicStages = copg_pkg::CordicStagesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [copg_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [copg_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 tick_valid_i,
  output logic                                 tick_ready_o,
  input  logic                                 tick_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [copg_pkg::TimeW-1:0]           elapsed_time_o,
  output logic signed [copg_pkg::PosW-1:0]     x_position_o,
  output logic signed [copg_pkg::PosW-1:0]     y_position_o
);
  import copg_pkg::*;

  `include "circular_orbit_position_generator_core_macros.svh"

  // Configuration registers.
  logic [RadiusW-1:0]    radius_q;
  logic [PhaseStepW-1:0] phase_step_q;
  logic [TimeStepW-1:0]  time_step_q;

  // Oscillator state.
  logic [PhaseBits-1:0]  phase_q;
  logic [TimeW-1:0]      time_cnt_q;

  logic [31:0]           p32;
  logic [PhaseBits-1:0]  phase_inc;
  logic [31:0]           quad_sum;
  logic [1:0]            quad;
  logic [31:0]           residual;
  logic                  tick_accept;
  copg_cell_t            front_d;

  // Entry register in front of the first cell.
  logic                  entry_valid_q;
  copg_cell_t            entry_data_q;

  // Position 0 is the entry register; position k+1 is the output of cell k.
  logic                  chain_valid [CordicStages+1];
  logic                  chain_ready [CordicStages+1];
  copg_cell_t            chain_data  [CordicStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= '0;
      phase_step_q <= '0;
      time_step_q  <= TimeStepW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRadius:    radius_q     <= cfg_data_i[RadiusW-1:0];
        CfgPhaseStep: phase_step_q <= cfg_data_i[PhaseStepW-1:0];
        CfgTimeStep:  time_step_q  <= cfg_data_i[TimeStepW-1:0];
        default: ;
      endcase
    end
  end

  // Align the accumulator to a 32-bit turn fraction and the step to the accumulator.
  if (PhaseBits >= 32) begin : g_wide_phase
    assign p32       = 32'(phase_q >> (PhaseBits - 32));
    assign phase_inc = PhaseBits'(phase_step_q) << (PhaseBits - 32);
  end else begin : g_narrow_phase
    assign p32       = 32'(phase_q) << (32 - PhaseBits);
    assign phase_inc = PhaseBits'(phase_step_q >> (32 - PhaseBits));
  end

  // Round to the nearest quarter turn; the residual lies in [-1/8, 1/8) turn.
  assign quad_sum = p32 + 32'h2000_0000;
  assign quad     = quad_sum[31:30];
  assign residual = p32 - {quad, 30'b0};

  always_comb begin
    front_d.elapsed = time_cnt_q;
    front_d.quad    = copg_quad_e'(quad);
    front_d.x       = CordicGain;
    front_d.y       = '0;
    front_d.z       = ZW'($signed(residual));
  end

  assign tick_ready_o = !entry_valid_q || chain_ready[0];
  assign tick_accept  = tick_valid_i && tick_ready_o && tick_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      time_cnt_q    <= '0;
      entry_valid_q <= 1'b0;
    end else begin
      if (tick_ready_o) begin
        entry_valid_q <= tick_valid_i && tick_i;
      end
      if (tick_accept) begin
        phase_q    <= phase_q + phase_inc;
        time_cnt_q <= time_cnt_q + TimeW'(time_step_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_accept) begin
      entry_data_q <= front_d;
    end
  end

  assign chain_valid[0] = entry_valid_q;
  assign chain_data[0]  = entry_data_q;

  // The CORDIC cell chain: one micro-rotation per cell.
  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    copg_cordic_cell #(
      .StageIdx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  copg_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (chain_valid[CordicStages]),
    .ready_o   (chain_ready[CordicStages]),
    .data_i    (chain_data[CordicStages]),
    .radius_i  (radius_q),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .elapsed_o (elapsed_time_o),
    .x_o       (x_position_o),
    .y_o       (y_position_o)
  );

  `COPG_ASSERT_NXT(zero_tick_keeps_state, tick_valid_i && tick_ready_o && !tick_i && !cfg_we_i, $stable(phase_q) && $stable(time_cnt_q), "zero tick changed the oscillator state")
  `COPG_ASSERT_NXT(tick_fills_entry, tick_accept, entry_valid_q, "accepted tick did not enter the pipeline")
  `COPG_ASSERT_NXT(time_advances, tick_accept, time_cnt_q == $past(time_cnt_q) + TimeW'($past(time_step_q)), "time counter did not advance by the step")

endmodule

[bench/circular_orbit_position_generator_core_test.sv]
// Self-checking testbench of the circular orbit position generator core.
`timescale 1ns / 100ps

module circular_orbit_position_generator_core_test;
  import copg_pkg::*;

  // The bench predicts with the same phase width and CORDIC depth that it builds the core with.
  localparam int PHASE_W = 32;
  localparam int STAGES = 16;
  // The settle pause outlasts the entry register, the CORDIC cell registers and the output stages.
  localparam int SETTLE_CYCLES = STAGES + 13;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 100000;
  localparam int REPORT_LIMIT = 10;

  // Register index that the core has no register for; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  // CORDIC start vector (gain 0.6072529 in Q2.30) and atan(2^-i) in turn * 2^32.
  localparam longint ROT_GAIN = 64'd652032874;
  localparam longint ROT_ANGLE [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef struct packed {
    logic [TimeW-1:0]       elapsed;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
  } orbit_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgRadius;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic tick_valid_i = 1'b0;
  logic tick_ready_o;
  logic tick_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [TimeW-1:0] elapsed_time_o;
  logic signed [PosW-1:0] x_position_o;
  logic signed [PosW-1:0] y_position_o;

  circular_orbit_position_generator_core #(
    .PhaseBits   (PHASE_W),
    .CordicStages(STAGES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .tick_valid_i  (tick_valid_i),
    .tick_ready_o  (tick_ready_o),
    .tick_i        (tick_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .elapsed_time_o(elapsed_time_o),
    .x_position_o  (x_position_o),
    .y_position_o  (y_position_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the configuration registers and of the oscillator state.
  logic [RadiusW-1:0] orbit_radius = '0;
  logic [PhaseStepW-1:0] orbit_phase_step = '0;
  logic [TimeStepW-1:0] orbit_time_step = 16'd1;
  logic [PHASE_W-1:0] orbit_phase = '0;
  logic [TimeW-1:0] orbit_time = '0;

  logic pending_ticks [$];
  orbit_sample_t expected_points [$];

  // Knobs that the stimulus sequence turns per phase of the run.
  bit bursts_on = 1'b0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Rounds a Q2.30 CORDIC output half up to Q.15 and clamps it to plus or minus one.
  function automatic longint round_to_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32768) r = 64'sd32768;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  // Scales a Q.15 trig value by the radius, truncating the magnitude of the product.
  function automatic logic [PosW-1:0] scale_by_radius(input longint c);
    longint mag;
    longint p;
    mag = (c < 0) ? -c : c;
    p = (mag * longint'(orbit_radius)) >>> 15;
    if (c < 0) p = -p;
    return p[PosW-1:0];
  endfunction

  // Computes the expected sample at a given phase and time. The phase is first rounded
  // to the nearest quarter turn; the CORDIC rotates through the residual of at most an
  // eighth turn, and the quadrant then maps the rotated vector back onto the circle.
  function automatic orbit_sample_t orbit_sample_at(input logic [31:0] p32,
                                                    input logic [TimeW-1:0] t);
    logic [31:0] quarter;
    logic [31:0] residual;
    copg_quad_e quad;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint cosv;
    longint sinv;
    orbit_sample_t s;
    int i;
    quarter = (p32 + 32'h2000_0000) >> 30;
    quad = copg_quad_e'(quarter[1:0]);
    residual = p32 - (quarter << 30);
    z = longint'($signed(residual));
    x = ROT_GAIN;
    y = 0;
    for (i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ROT_ANGLE[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ROT_ANGLE[i];
      end
    end
    x = round_to_q15(x);
    y = round_to_q15(y);
    case (quad)
      Quad0: begin
        cosv = x;
        sinv = y;
      end
      Quad90: begin
        cosv = -y;
        sinv = x;
      end
      Quad180: begin
        cosv = -x;
        sinv = -y;
      end
      default: begin
        cosv = y;
        sinv = -x;
      end
    endcase
    s.elapsed = t;
    s.x = scale_by_radius(cosv);
    s.y = scale_by_radius(sinv);
    return s;
  endfunction

  // Tick driver. On every accepted transaction with the tick set it records the expected
  // sample and advances the shadow phase and time; a cleared tick changes nothing. When
  // the channel is free it either idles for a random burst or offers the next pending item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_i <= 1'b0;
      tick_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (tick_valid_i && tick_ready_o && tick_i) begin
        expected_points.push_back(orbit_sample_at(orbit_phase, orbit_time));
        orbit_phase = orbit_phase + orbit_phase_step;
        orbit_time = orbit_time + TimeW'(orbit_time_step);
      end
      if (!tick_valid_i || tick_ready_o) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          tick_valid_i <= 1'b0;
        end else if (pending_ticks.size() == 0) begin
          tick_valid_i <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 12);
          tick_valid_i <= 1'b0;
        end else begin
          tick_valid_i <= 1'b1;
          tick_i <= pending_ticks.pop_front();
        end
      end
    end
  end

  // Long receiver hold-off, counted here so that the monitor only has to look at it.
  // While it runs the core fills up and must drop tick_ready_o.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Result monitor. Every accepted result transaction is checked field by field against
  // the oldest expected sample; the ready line stalls in random bursts and during a hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0d: unexpected result time=%0d x=%0d y=%0d", cycle_count,
                     elapsed_time_o, x_position_o, y_position_o);
          end
        end else begin
          orbit_sample_t want;
          want = expected_points.pop_front();
          if (want.elapsed !== elapsed_time_o || want.x !== x_position_o ||
              want.y !== y_position_o) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0d: result mismatch: expected time=%0d x=%0d y=%0d, %s%0d x=%0d y=%0d",
                       cycle_count, want.elapsed, want.x, want.y, "got time=",
                       elapsed_time_o, x_position_o, y_position_o);
            end
          end
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL circular_orbit_position_generator_core");
      $finish;
    end
  end

  // Writes one register and mirrors the write in the shadow copy; unknown indexes are dropped.
  task automatic cfg_write(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    case (index)
      CfgRadius:    orbit_radius = data[RadiusW-1:0];
      CfgPhaseStep: orbit_phase_step = data[PhaseStepW-1:0];
      CfgTimeStep:  orbit_time_step = data[TimeStepW-1:0];
      default:      ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_ticks(input int count, input logic value);
    repeat (count) pending_ticks.push_back(value);
  endtask

  // Random items: most carry a tick, some are empty transactions that the core drops.
  task automatic push_random_ticks(input int count);
    repeat (count) pending_ticks.push_back($urandom_range(0, 6) != 0);
  endtask

  // Waits until every item is sent and every result is back, then waits out the settle pause
  // before the configuration may change. The queues and the valid line are looked at on the
  // falling edge, after the clocked blocks have settled.
  task automatic settle();
    while (pending_ticks.size() != 0 || tick_valid_i || expected_points.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int ph;
    logic [RadiusW-1:0] r;
    logic [PhaseStepW-1:0] ps;
    logic [TimeStepW-1:0] ts;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: zero radius, so the very first sample is all zeros.
    push_ticks(1, 1'b1);
    push_ticks(1, 1'b0);
    push_ticks(1, 1'b1);
    settle();

    // Full radius and quarter-turn steps: one sample on each axis, cosine clamped at one.
    cfg_write(CfgSpare, 32'hFFFF_FFFF);
    cfg_write(CfgRadius, 32'hFFFF_FFFF);
    cfg_write(CfgPhaseStep, 32'h4000_0000);
    cfg_close();
    push_ticks(4, 1'b1);
    settle();

    // Eighth-turn steps land on the quadrant rounding boundaries at every other sample.
    cfg_write(CfgPhaseStep, 32'h2000_0000);
    cfg_close();
    push_ticks(8, 1'b1);
    settle();

    // Largest phase step (one unit backward), time frozen, tiny radius.
    cfg_write(CfgRadius, 32'hABCD_0001);
    cfg_write(CfgPhaseStep, 32'hFFFF_FFFF);
    cfg_write(CfgTimeStep, 32'hFFFF_0000);
    cfg_close();
    push_ticks(3, 1'b1);
    settle();

    // Half-turn steps with the largest time step, plus a dropped transaction.
    cfg_write(CfgRadius, 32'h0000_8000);
    cfg_write(CfgPhaseStep, 32'h8000_0000);
    cfg_write(CfgTimeStep, 32'h0000_FFFF);
    cfg_close();
    push_ticks(2, 1'b1);
    push_ticks(1, 1'b0);
    push_ticks(1, 1'b1);
    settle();

    // Random phases: new settings each time, extremes favored, idling on in most phases.
    for (ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 4))
        0: r = '0;
        1: r = '1;
        2: r = 16'd1;
        default: r = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0: ps = '0;
        1: ps = '1;
        2: ps = 32'h8000_0000;
        3: ps = $urandom_range(1, 4096);
        default: ps = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0: ts = '0;
        1: ts = '1;
        2: ts = 16'd1;
        default: ts = $urandom();
      endcase
      cfg_write(CfgRadius, {16'($urandom()), r});
      cfg_write(CfgPhaseStep, ps);
      cfg_write(CfgTimeStep, {16'($urandom()), ts});
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(CfgSpare, $urandom());
      end
      cfg_close();
      bursts_on = (ph % 3 != 2) && (ph != 4);
      push_random_ticks(58);
      if (ph == 4) begin
        // The sender keeps offering while the receiver holds off for a long stretch.
        hold_go = 1'b1;
        wait (hold_left != 0);
        hold_go = 1'b0;
      end
      settle();
    end

    // Last part, with no idling: back-to-back ticks at the largest time step.
    bursts_on = 1'b0;
    cfg_write(CfgRadius, $urandom());
    cfg_write(CfgPhaseStep, $urandom());
    cfg_write(CfgTimeStep, 32'h0000_FFFF);
    cfg_close();
    push_ticks(48, 1'b1);
    settle();

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("PASS circular_orbit_position_generator_core");
    end else begin
      $display("FAIL circular_orbit_position_generator_core");
    end
    $finish;
  end

endmodule
